// File: src/fspd_pkg.sv
// ============================================================================
// Fan speed PD controller package
// Shared types and constants of the incremental PD fan drive controller.
// ============================================================================
package fspd_pkg;

    localparam int SPD_W     = 16;
    localparam int QUO_W     = 13;
    localparam int DRV_W     = 16;
    localparam int GAIN_W    = 8;
    localparam int PROD_W    = QUO_W + GAIN_W;
    localparam int STEP_W    = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Division by ten as a multiplication by a scaled reciprocal.
    // It is exact for every 16-bit dividend.
    localparam int                DIV10_MUL_W = 17;
    localparam logic [16:0]       DIV10_MUL   = 17'd52429;
    localparam int                DIV10_SHIFT = 19;

    localparam logic [STEP_W-1:0] STEP_UP_MAX   = 7'd100;
    localparam logic [STEP_W-1:0] STEP_DOWN_MAX = 7'd18;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_DRIVE = 3'd4;

    localparam logic [GAIN_W-1:0] RST_GAIN_P      = 8'd10;
    localparam logic [GAIN_W-1:0] RST_GAIN_D      = 8'd8;
    localparam logic [DRV_W-1:0]  RST_DRIVE_MAX   = 16'd1000;
    localparam logic [DRV_W-1:0]  RST_DRIVE_MIN   = 16'd100;
    localparam logic [DRV_W-1:0]  RST_START_DRIVE = 16'd200;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_d;
        logic [DRV_W-1:0]  drive_max;
        logic [DRV_W-1:0]  drive_min;
        logic [DRV_W-1:0]  start_drive;
    } cfg_t;

    typedef struct packed {
        logic             kind;
        logic [QUO_W-1:0] tgt_q;
        logic [QUO_W-1:0] meas_q;
    } upd_t;

endpackage

// File: src/fan_speed_incremental_pd.sv
// ============================================================================
// Fan speed incremental PD controller
// Top level: configuration registers, input stage and PD step with history.
// ============================================================================
// Each request is either a control update or a fan-off reset. The block takes
// one request every clock cycle unless a held result waits on out_ready.
// It passes the input register, where both speeds are divided by ten, and then
// the result register, loaded by the step logic that forms the error, the PD
// step and the clamped drive. The error, direction and drive history update in
// the same cycle as the result register, so back-to-back requests always see
// the history left by the request before them. Register writes take effect on
// the next cycle and should only be made while idle.
module fan_speed_incremental_pd (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [fspd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fspd_pkg::CFG_DAT_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            kind,
    input  logic [fspd_pkg::SPD_W-1:0]      target_speed,
    input  logic [fspd_pkg::SPD_W-1:0]      measured_speed,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [fspd_pkg::DRV_W-1:0]      drive,
    output logic                            slowing
);

    fspd_pkg::cfg_t cfg;
    fspd_pkg::upd_t upd;
    logic           upd_valid;
    logic           advance;

    fspd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fspd_in_stage u_in_stage (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .target_speed   (target_speed),
        .measured_speed (measured_speed),
        .advance        (advance),
        .upd_valid      (upd_valid),
        .upd            (upd)
    );

    fspd_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd_valid (upd_valid),
        .upd       (upd),
        .cfg       (cfg),
        .advance   (advance),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .drive     (drive),
        .slowing   (slowing)
    );

endmodule

// File: src/fspd_cfg.sv
// ============================================================================
// Fan speed PD configuration registers
// Holds the gains, drive limits and start drive written through the write port.
// ============================================================================
module fspd_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [fspd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fspd_pkg::CFG_DAT_W-1:0]  cfg_data,
    output fspd_pkg::cfg_t                  cfg
);

    fspd_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p      <= fspd_pkg::RST_GAIN_P;
            cfg_reg.gain_d      <= fspd_pkg::RST_GAIN_D;
            cfg_reg.drive_max   <= fspd_pkg::RST_DRIVE_MAX;
            cfg_reg.drive_min   <= fspd_pkg::RST_DRIVE_MIN;
            cfg_reg.start_drive <= fspd_pkg::RST_START_DRIVE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fspd_pkg::REG_GAIN_P:      cfg_reg.gain_p      <= cfg_data[fspd_pkg::GAIN_W-1:0];
                fspd_pkg::REG_GAIN_D:      cfg_reg.gain_d      <= cfg_data[fspd_pkg::GAIN_W-1:0];
                fspd_pkg::REG_DRIVE_MAX:   cfg_reg.drive_max   <= cfg_data;
                fspd_pkg::REG_DRIVE_MIN:   cfg_reg.drive_min   <= cfg_data;
                fspd_pkg::REG_START_DRIVE: cfg_reg.start_drive <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/fspd_in_stage.sv
// ============================================================================
// Fan speed PD input stage
// Divides both speeds by ten and holds the request in the input register.
// ============================================================================
module fspd_in_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        kind,
    input  logic [fspd_pkg::SPD_W-1:0]  target_speed,
    input  logic [fspd_pkg::SPD_W-1:0]  measured_speed,
    input  logic                        advance,
    output logic                        upd_valid,
    output fspd_pkg::upd_t              upd
);

    localparam int PROD_W = fspd_pkg::SPD_W + fspd_pkg::DIV10_MUL_W;

    logic [PROD_W-1:0]  tgt_prod;
    logic [PROD_W-1:0]  meas_prod;
    logic               valid_reg;
    logic               valid_next;
    fspd_pkg::upd_t     upd_reg;
    logic               take;

    assign tgt_prod  = PROD_W'(target_speed) * PROD_W'(fspd_pkg::DIV10_MUL);
    assign meas_prod = PROD_W'(measured_speed) * PROD_W'(fspd_pkg::DIV10_MUL);

    assign in_ready = !valid_reg || advance;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            upd_reg.kind   <= kind;
            upd_reg.tgt_q  <= tgt_prod[fspd_pkg::DIV10_SHIFT +: fspd_pkg::QUO_W];
            upd_reg.meas_q <= meas_prod[fspd_pkg::DIV10_SHIFT +: fspd_pkg::QUO_W];
        end
    end

    assign upd_valid = valid_reg;
    assign upd       = upd_reg;

endmodule

// File: src/fspd_step.sv
// ============================================================================
// Fan speed PD step
// Forms the error, the PD step and the clamped drive, and updates the history.
// ============================================================================
module fspd_step (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        upd_valid,
    input  fspd_pkg::upd_t              upd,
    input  fspd_pkg::cfg_t              cfg,
    output logic                        advance,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [fspd_pkg::DRV_W-1:0]  drive,
    output logic                        slowing
);

    localparam int QW = fspd_pkg::QUO_W;
    localparam int PW = fspd_pkg::PROD_W;
    localparam int DW = fspd_pkg::DRV_W;
    localparam int SW = fspd_pkg::STEP_W;

    logic [QW-1:0]  prev_error_reg;
    logic           prev_slowing_reg;
    logic [DW-1:0]  prev_drive_reg;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic [DW-1:0]  drive_reg;
    logic           slowing_reg;

    logic           slow;
    logic [QW-1:0]  err;
    logic [PW-1:0]  p_term;
    logic [PW-1:0]  d_term;
    logic           same_dir;
    logic           p_ge;
    logic [PW:0]    diff;
    logic           decrease;
    logic [SW-1:0]  step_dn;
    logic [SW-1:0]  step_up;
    logic [DW-1:0]  dn_val;
    logic [DW:0]    up_val;
    logic [DW:0]    raw;
    logic [DW-1:0]  clamped;
    logic [DW-1:0]  drive_new;
    logic           slow_new;
    logic [QW-1:0]  err_new;

    assign slow = !(upd.tgt_q > upd.meas_q);
    assign err  = slow ? (upd.meas_q - upd.tgt_q) : (upd.tgt_q - upd.meas_q);

    assign p_term = PW'(err) * PW'(cfg.gain_p);
    assign d_term = PW'(prev_error_reg) * PW'(cfg.gain_d);

    assign same_dir = (slow == prev_slowing_reg);
    assign p_ge     = (p_term >= d_term);

    always_comb
    begin
        if (same_dir)
        begin
            diff     = p_ge ? {1'b0, p_term - d_term} : {1'b0, d_term - p_term};
            decrease = slow ? p_ge : !p_ge;
        end
        else
        begin
            diff     = {1'b0, p_term} + {1'b0, d_term};
            decrease = slow;
        end
    end

    assign step_dn = (diff > (PW+1)'(fspd_pkg::STEP_DOWN_MAX)) ? fspd_pkg::STEP_DOWN_MAX
                                                              : diff[SW-1:0];
    assign step_up = (diff > (PW+1)'(fspd_pkg::STEP_UP_MAX)) ? fspd_pkg::STEP_UP_MAX
                                                            : diff[SW-1:0];

    // The decrease is an absolute difference, so a drive below the step folds back up.
    assign dn_val = (prev_drive_reg > DW'(step_dn)) ? (prev_drive_reg - DW'(step_dn))
                                                   : (DW'(step_dn) - prev_drive_reg);
    assign up_val = {1'b0, prev_drive_reg} + (DW+1)'(step_up);
    assign raw    = decrease ? {1'b0, dn_val} : up_val;

    always_comb
    begin
        if (raw > {1'b0, cfg.drive_max})
            clamped = cfg.drive_max;
        else if (raw < {1'b0, cfg.drive_min})
            clamped = cfg.drive_min;
        else
            clamped = raw[DW-1:0];
    end

    always_comb
    begin
        if (upd.kind)
        begin
            drive_new = cfg.start_drive;
            slow_new  = 1'b0;
            err_new   = '0;
        end
        else
        begin
            drive_new = clamped;
            slow_new  = slow;
            err_new   = err;
        end
    end

    assign advance = upd_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            prev_error_reg   <= '0;
            prev_slowing_reg <= 1'b0;
            prev_drive_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                prev_error_reg   <= err_new;
                prev_slowing_reg <= slow_new;
                prev_drive_reg   <= drive_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            drive_reg   <= drive_new;
            slowing_reg <= slow_new;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign slowing   = slowing_reg;

endmodule
